@@ design/ghash_pkg.sv @@
// Shared widths, command codes and constants for the GHASH accumulator.
`default_nettype none

package ghash_pkg;

    localparam int unsigned HALF_W  = 64;
    localparam int unsigned BLOCK_W = 2 * HALF_W;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned BYTES   = BLOCK_W / BYTE_W;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned BITS_W  = 8;
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned INDEX_W = 1;
    localparam int unsigned IN_W    = 136;
    localparam int unsigned OUT_W   = BLOCK_W;

    localparam logic [BYTE_W-1:0]  GF_REDUCE_TOP = 8'hE1;
    localparam logic [BYTE_W-1:0]  BYTE_ONES     = 8'hFF;
    localparam logic [COUNT_W-1:0] FULL_COUNT    = 5'd16;

    typedef enum logic [CMD_W-1:0] {
        CMD_AAD    = 2'd0,
        CMD_CIPHER = 2'd1,
        CMD_FINISH = 2'd2
    } cmd_t;

    localparam logic [INDEX_W-1:0] REG_SUBKEY_HIGH = 1'b0;
    localparam logic [INDEX_W-1:0] REG_SUBKEY_LOW  = 1'b1;

endpackage

`default_nettype wire

@@ design/ghash_accumulator_unit.sv @@
// Top level of the GHASH accumulator: input stage, accumulator and hash output register.
//
//  channel  | direction | tdata / payload                              | tuser
//  ---------+-----------+----------------------------------------------+--------
//  s_*      | in        | byte_count[4:0] block_high[68:5] block_low   | command
//           |           | [132:69], zero pad [135:133]                 |
//  m_*      | out       | hash_high[63:0] hash_low[127:64]             | -
//  cfg_*    | in        | cfg_index (0 subkey_high, 1 subkey_low),     | -
//           |           | cfg_data                                     |
//
// One block per cycle unless a finish waits: a beat is registered, then folded into the
// accumulator by the combinational GF(2^128) multiplier. A finish beat's hash sets the
// output register and m_tvalid. Only a finish beat waits for the output register; data
// beats flow while a hash is stalled. Reset clears the accumulator, counters and subkey.
`default_nettype none

module ghash_accumulator_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // byte_count, block_high, block_low, zero pad
    input  logic [ghash_pkg::IN_W-1:0]       s_tdata,
    // command
    input  logic [ghash_pkg::CMD_W-1:0]      s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // hash_high, hash_low
    output logic [ghash_pkg::OUT_W-1:0]      m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ghash_pkg::INDEX_W-1:0]    cfg_index,
    input  logic [ghash_pkg::HALF_W-1:0]     cfg_data
);

    localparam int unsigned HW = ghash_pkg::HALF_W;
    localparam int unsigned BW = ghash_pkg::BLOCK_W;
    localparam int unsigned CW = ghash_pkg::COUNT_W;
    localparam int unsigned BY = ghash_pkg::BYTES;
    localparam int unsigned YW = ghash_pkg::BYTE_W;

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic [ghash_pkg::CMD_W-1:0]   s1_cmd_reg;
    logic [BW-1:0]                 s1_block_reg;
    logic [ghash_pkg::BITS_W-1:0]  s1_bits_reg;
    logic [BW-1:0]                 acc_reg;
    logic [BW-1:0]                 acc_next;
    logic [HW-1:0]                 aad_len_reg;
    logic [HW-1:0]                 aad_len_next;
    logic [HW-1:0]                 cipher_len_reg;
    logic [HW-1:0]                 cipher_len_next;
    logic [HW-1:0]                 subkey_high_reg;
    logic [HW-1:0]                 subkey_low_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [BW-1:0]                 out_hash_reg;

    logic                          s_fire;
    logic                          s1_finish;
    logic                          s1_fire;
    logic                          out_free;
    logic [CW-1:0]                 n_sat;
    logic [BW-1:0]                 in_block;
    logic [BW-1:0]                 in_masked;
    logic [BW-1:0]                 operand;
    logic [BW-1:0]                 product;

    assign cfg_ready = 1'b1;
    assign s_fire    = s_tvalid && s_tready;
    assign s1_finish = (s1_cmd_reg == ghash_pkg::CMD_FINISH);
    assign out_free  = !out_valid_reg || m_tready;
    assign s1_fire   = s1_valid_reg && (!s1_finish || out_free);
    assign s_tready  = !s1_valid_reg || s1_fire;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {out_hash_reg[HW-1:0], out_hash_reg[BW-1:HW]};

    // saturate the count and zero the bytes past it
    always_comb
    begin
        n_sat    = (s_tdata[CW-1:0] > ghash_pkg::FULL_COUNT) ? ghash_pkg::FULL_COUNT
                                                            : s_tdata[CW-1:0];
        in_block = {s_tdata[CW+HW-1:CW], s_tdata[CW+BW-1:CW+HW]};
        for (int b = 0; b < BY; b++)
        begin
            in_masked[BW-1-b*YW -: YW] = (CW'(b) < n_sat)
                ? (in_block[BW-1-b*YW -: YW] & ghash_pkg::BYTE_ONES) : '0;
        end
    end

    assign operand = acc_reg ^ (s1_finish ? {aad_len_reg, cipher_len_reg} : s1_block_reg);

    ghash_gf_mult u_gf_mult (
        .a       (operand),
        .h       ({subkey_high_reg, subkey_low_reg}),
        .product (product)
    );

    always_comb
    begin
        acc_next        = acc_reg;
        aad_len_next    = aad_len_reg;
        cipher_len_next = cipher_len_reg;
        if (s1_fire)
        begin
            unique case (s1_cmd_reg)
                ghash_pkg::CMD_AAD:
                begin
                    acc_next     = product;
                    aad_len_next = aad_len_reg + HW'(s1_bits_reg);
                end
                ghash_pkg::CMD_CIPHER:
                begin
                    acc_next        = product;
                    cipher_len_next = cipher_len_reg + HW'(s1_bits_reg);
                end
                ghash_pkg::CMD_FINISH:
                begin
                    acc_next        = '0;
                    aad_len_next    = '0;
                    cipher_len_next = '0;
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_fire && s1_finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            acc_reg         <= '0;
            aad_len_reg     <= '0;
            cipher_len_reg  <= '0;
            subkey_high_reg <= '0;
            subkey_low_reg  <= '0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            acc_reg        <= acc_next;
            aad_len_reg    <= aad_len_next;
            cipher_len_reg <= cipher_len_next;
            if (cfg_valid && cfg_ready && cfg_index == ghash_pkg::REG_SUBKEY_HIGH)
            begin
                subkey_high_reg <= cfg_data;
            end
            if (cfg_valid && cfg_ready && cfg_index == ghash_pkg::REG_SUBKEY_LOW)
            begin
                subkey_low_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_cmd_reg   <= s_tuser;
            s1_block_reg <= in_masked;
            s1_bits_reg  <= {n_sat, 3'b000};
        end
        if (s1_fire && s1_finish)
        begin
            out_hash_reg <= product;
        end
    end

    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_finish) |=> (aad_len_reg == '0 && cipher_len_reg == '0
                                    && acc_reg == '0))
        else $error("state not cleared after finish");

    a_finish_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_finish) |-> out_free)
        else $error("finish beat overwrote a pending hash");

    a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && s1_finish && out_valid_reg && !m_tready))
        else $error("input stalled without a blocked finish");

    a_hash_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s1_fire && s1_finish))
        else $error("hash appeared without a finish beat");

endmodule

`default_nettype wire

@@ design/ghash_gf_mult.sv @@
// GF(2^128) multiplier in GCM bit order with reflected 0xE1 reduction.
`default_nettype none

module ghash_gf_mult (
    input  logic [ghash_pkg::BLOCK_W-1:0] a,
    input  logic [ghash_pkg::BLOCK_W-1:0] h,
    output logic [ghash_pkg::BLOCK_W-1:0] product
);

    localparam int unsigned N      = ghash_pkg::BLOCK_W;
    localparam int unsigned TAPS   = ghash_pkg::BYTE_W;
    localparam int unsigned PROD_W = 2 * N - 1;
    localparam int unsigned HI_W   = N - 1;
    localparam int unsigned F1_W   = HI_W + TAPS - 1;
    localparam int unsigned OV_W   = F1_W - N;
    localparam int unsigned F2_W   = OV_W + TAPS - 1;

    logic [N-1:0]      ar;
    logic [N-1:0]      hr;
    logic [N-1:0]      res;
    logic [PROD_W-1:0] prod;
    logic [F1_W-1:0]   fold1;
    logic [F2_W-1:0]   fold2;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            ar[i] = a[N-1-i];
            hr[i] = h[N-1-i];
        end

        prod = '0;
        for (int i = 0; i < N; i++)
        begin
            if (ar[i])
            begin
                prod = prod ^ ({{(PROD_W-N){1'b0}}, hr} << i);
            end
        end

        // fold degrees 128 and up back down with x^128 = 1 + x + x^2 + x^7
        fold1 = '0;
        for (int k = 0; k < TAPS; k++)
        begin
            if (ghash_pkg::GF_REDUCE_TOP[TAPS-1-k])
            begin
                fold1 = fold1 ^ ({{(F1_W-HI_W){1'b0}}, prod[PROD_W-1:N]} << k);
            end
        end

        fold2 = '0;
        for (int k = 0; k < TAPS; k++)
        begin
            if (ghash_pkg::GF_REDUCE_TOP[TAPS-1-k])
            begin
                fold2 = fold2 ^ ({{(F2_W-OV_W){1'b0}}, fold1[F1_W-1:N]} << k);
            end
        end

        res = prod[N-1:0] ^ fold1[N-1:0] ^ {{(N-F2_W){1'b0}}, fold2};

        for (int i = 0; i < N; i++)
        begin
            product[N-1-i] = res[i];
        end
    end

endmodule

`default_nettype wire
